// ----- sv/mdss_pkg.sv -----
// Shared constants, command codes and the segment decode table for the display scan serializer.
package mdss_pkg;

  localparam int GRID_COUNT    = 10;
  localparam int WORD_BITS     = 20;
  localparam int SEGMENT_SHIFT = 10;

  localparam logic [0:0] CMD_WRITE = 1'b0;
  localparam logic [0:0] CMD_TICK  = 1'b1;

  localparam logic [3:0] CODE_BLANK = 4'd10;
  localparam logic [3:0] CODE_DASH  = 4'd11;

  function automatic logic [7:0] seg_decode(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:       seg = 8'b11101101;
      4'd1:       seg = 8'b01100000;
      4'd2:       seg = 8'b11001110;
      4'd3:       seg = 8'b11101010;
      4'd4:       seg = 8'b01100011;
      4'd5:       seg = 8'b10101011;
      4'd6:       seg = 8'b10101111;
      4'd7:       seg = 8'b11100000;
      4'd8:       seg = 8'b11101111;
      4'd9:       seg = 8'b11101011;
      CODE_BLANK: seg = 8'b00000000;
      CODE_DASH:  seg = 8'b00000010;
      default:    seg = 8'b00000000;
    endcase
    return seg;
  endfunction

endpackage

// ----- sv/mdss_req_if.sv -----
// Command channel: character writes and refresh ticks.
interface mdss_req_if;
  logic       valid;
  logic       ready;
  logic [0:0] command;
  logic [3:0] grid_index;
  logic [3:0] char_code;

  modport source (output valid, output command, output grid_index, output char_code,
                  input ready);
  modport sink (input valid, input command, input grid_index, input char_code,
                output ready);
endinterface

// ----- sv/mdss_res_if.sv -----
// Result channel: one serial bit per item with its grid and last-bit mark.
interface mdss_res_if;
  logic       valid;
  logic       ready;
  logic       serial_data;
  logic [3:0] active_grid;
  logic       last_bit;

  modport source (output valid, output serial_data, output active_grid, output last_bit,
                  input ready);
  modport sink (input valid, input serial_data, input active_grid, input last_bit,
                output ready);
endinterface

// ----- sv/multiplexed_display_scan_serializer.sv -----
// Multiplexed display scan serializer: command register, character store and bit shifter.
//
// Commands enter a one-deep input register, one per cycle while no tick waits
// in it for the shifter. A write command updates the character store as it
// leaves that register and yields nothing; a grid index at or above GRID_COUNT
// is dropped. A refresh tick reads the store at the scan position, builds the
// grid-select and segment word and loads it into the shifter, which then
// presents WORD_BITS result items, most significant bit first, one per cycle
// while the result side is ready; the final item carries last_bit. The next tick
// loads in the same cycle that the previous tick's last bit is taken. Writes keep
// flowing while a tick shifts out, unless another tick waits in the input register.
module multiplexed_display_scan_serializer #(
  parameter int GRID_COUNT = mdss_pkg::GRID_COUNT,
  parameter int WORD_BITS  = mdss_pkg::WORD_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mdss_req_if.sink   request,
  mdss_res_if.source result
);

  localparam int GridBits = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;
  localparam int CntBits  = $clog2(WORD_BITS);

  logic                q_valid;
  logic [0:0]          q_command;
  logic [3:0]          q_grid;
  logic [3:0]          q_code;

  logic [3:0]          char_store [GRID_COUNT];
  logic [GridBits-1:0] scan;

  logic                busy;
  logic [WORD_BITS-1:0] word;
  logic [CntBits-1:0]  cnt;
  logic [3:0]          grid_out;

  logic                advance;
  logic                load;
  logic                store_write;
  logic [WORD_BITS-1:0] word_next;
  logic [GridBits-1:0] scan_next;

  assign advance     = (q_command == mdss_pkg::CMD_WRITE) || !busy ||
                       (result.ready && cnt == '0);
  assign load        = q_valid && (q_command == mdss_pkg::CMD_TICK) && advance;
  assign store_write = q_valid && (q_command == mdss_pkg::CMD_WRITE) &&
                       ({1'b0, q_grid} < 5'(GRID_COUNT));
  assign request.ready = !q_valid || advance;

  assign word_next = (WORD_BITS'(1) << scan) |
                     (WORD_BITS'(mdss_pkg::seg_decode(char_store[scan]))
                      << mdss_pkg::SEGMENT_SHIFT);
  assign scan_next = (scan == GridBits'(GRID_COUNT - 1)) ? '0 : scan + 1'b1;

  assign result.valid       = busy;
  assign result.serial_data = word[cnt];
  assign result.active_grid = grid_out;
  assign result.last_bit    = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (request.valid && request.ready) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
    if (request.valid && request.ready) begin
      q_command <= request.command;
      q_grid    <= request.grid_index;
      q_code    <= request.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < GRID_COUNT; k++) begin
        char_store[k] <= (k < 9) ? 4'(10 - k) : mdss_pkg::CODE_BLANK;
      end
      scan <= '0;
    end else begin
      if (store_write) begin
        char_store[q_grid[GridBits-1:0]] <= q_code;
      end
      if (load) begin
        scan <= scan_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= CntBits'(WORD_BITS - 1);
    end else if (busy && result.ready) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
    if (load) begin
      word     <= word_next;
      grid_out <= 4'(scan);
    end
  end

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.last_bit && !load) |=> !result.valid)
    else $error("shifter stayed busy after its last bit");

  a_load_grid: assert property (@(posedge clk) disable iff (rst)
    load |=> (result.active_grid == 4'($past(scan)) && result.valid))
    else $error("loaded tick shows wrong grid");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    32'(scan) < GRID_COUNT)
    else $error("scan position out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (result.ready && result.last_bit)))
    else $error("tick loaded over a word still shifting");

endmodule
